/* src/ilst_pkg.sv */
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared types and constants of the indexed list store: request and response
// payloads, action and status codes, and the classification of a request.
// ----------------------------------------------------------------------------
`default_nettype none

package ilst_pkg;

  localparam int unsigned Capacity = 64;

  localparam logic [2:0] ActRead    = 3'd0;
  localparam logic [2:0] ActInsHead = 3'd1;
  localparam logic [2:0] ActInsTail = 3'd2;
  localparam logic [2:0] ActInsPos  = 3'd3;
  localparam logic [2:0] ActDelete  = 3'd4;

  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  localparam logic signed [31:0] MissValue = -32'sd1;

  typedef struct packed {
    logic [2:0]         action;
    logic [6:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         list_length;
  } rsp_t;

  typedef enum logic [2:0] {
    KindRead   = 3'd0,
    KindInsert = 3'd1,
    KindDelete = 3'd2,
    KindRange  = 3'd3,
    KindFull   = 3'd4,
    KindNop    = 3'd5
  } kind_e;

  typedef struct packed {
    logic load;
    logic decide_rd;
    logic shift_rd;
    logic shift_wr;
    logic finish;
    logic rsp_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  more;
  } stat_t;

endpackage

`default_nettype wire

/* src/indexed_list_store.sv */
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit values with bounded capacity: read, insert
// at head, tail or position, and delete at position, one response per request.
// ----------------------------------------------------------------------------
// The list lives in a single memory kept in position order, so an insert or
// a delete moves every element behind the affected position by one slot,
// one element per read and write pair on the memory port. The next request
// is taken only once the block is back in its idle state, after the current
// one has been handed to the output register. A finished response waits in
// the output register while the next request is already being worked on.
`default_nettype none

module indexed_list_store #(
  parameter int unsigned Capacity = ilst_pkg::Capacity
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ilst_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ilst_pkg::rsp_t      out_rsp_o
);

  ilst_pkg::cmd_t  cmd;
  ilst_pkg::stat_t stat;

  ilst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ilst_datapath #(
    .Capacity (Capacity)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_rsp_o (out_rsp_o)
  );

endmodule

`default_nettype wire

/* src/ilst_datapath.sv */
// ----------------------------------------------------------------------------
// ilst_datapath
// Element memory, element count, request registers and the shift pointer.
// Moves one element per read and write pair on command of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ilst_datapath #(
  parameter int unsigned Capacity = ilst_pkg::Capacity
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ilst_pkg::req_t in_req_i,
  input  wire ilst_pkg::cmd_t cmd_i,
  output ilst_pkg::stat_t     stat_o,
  output ilst_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned MW = (CW > 7) ? CW : 7;

  logic signed [31:0] mem [Capacity];

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      epos_q;
  ilst_pkg::kind_e    kind_q;
  logic signed [31:0] value_q;
  logic signed [31:0] rdata_q;
  ilst_pkg::rsp_t     rsp_q;

  logic [MW-1:0]      pos_ext;
  logic [MW-1:0]      cnt_ext;
  logic [MW-1:0]      ins_pos;
  logic [MW-1:0]      new_epos;
  ilst_pkg::kind_e    new_kind;
  logic               is_full;
  logic               is_ins;

  logic [CW-1:0]      src_idx;
  logic [CW-1:0]      raddr;
  logic [CW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               re;
  logic               we;
  logic [1:0]         rsp_status;

  assign pos_ext = MW'(in_req_i.position);
  assign cnt_ext = MW'(count_q);
  assign is_full = (count_q == CW'(Capacity));

  always_comb begin
    ins_pos  = '0;
    new_epos = pos_ext;
    is_ins   = 1'b0;
    new_kind = ilst_pkg::KindNop;
    unique case (in_req_i.action)
      ilst_pkg::ActRead: begin
        new_kind = (pos_ext < cnt_ext) ? ilst_pkg::KindRead : ilst_pkg::KindRange;
      end
      ilst_pkg::ActInsHead: begin
        ins_pos = '0;
        is_ins  = 1'b1;
      end
      ilst_pkg::ActInsTail: begin
        ins_pos = cnt_ext;
        is_ins  = 1'b1;
      end
      ilst_pkg::ActInsPos: begin
        ins_pos = pos_ext;
        is_ins  = 1'b1;
      end
      ilst_pkg::ActDelete: begin
        new_kind = (pos_ext < cnt_ext) ? ilst_pkg::KindDelete : ilst_pkg::KindRange;
      end
      default: begin
        new_kind = ilst_pkg::KindNop;
      end
    endcase
    if (is_ins) begin
      new_epos = ins_pos;
      if (ins_pos > cnt_ext) begin
        new_kind = ilst_pkg::KindRange;
      end else if (is_full) begin
        new_kind = ilst_pkg::KindFull;
      end else begin
        new_kind = ilst_pkg::KindInsert;
      end
    end
  end

  always_comb begin
    stat_o.kind = kind_q;
    if (kind_q == ilst_pkg::KindInsert) begin
      stat_o.more = (idx_q > epos_q);
    end else begin
      stat_o.more = ((CW + 1)'(idx_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);
    end
  end

  assign src_idx = (kind_q == ilst_pkg::KindInsert) ? (idx_q - CW'(1)) : (idx_q + CW'(1));
  assign raddr   = cmd_i.shift_rd ? src_idx : epos_q;
  assign re      = cmd_i.decide_rd | cmd_i.shift_rd;
  assign we      = cmd_i.shift_wr | (cmd_i.finish & (kind_q == ilst_pkg::KindInsert));
  assign waddr   = cmd_i.shift_wr ? idx_q : epos_q;
  assign wdata   = cmd_i.shift_wr ? rdata_q : value_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr[AW-1:0]];
    end
  end

  always_comb begin
    idx_d   = idx_q;
    count_d = count_q;
    if (cmd_i.load) begin
      idx_d = (new_kind == ilst_pkg::KindInsert) ? count_q : new_epos[CW-1:0];
    end else if (cmd_i.shift_wr) begin
      idx_d = src_idx;
    end
    if (cmd_i.finish) begin
      if (kind_q == ilst_pkg::KindInsert) begin
        count_d = count_q + CW'(1);
      end else if (kind_q == ilst_pkg::KindDelete) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      kind_q  <= ilst_pkg::KindNop;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.load) begin
        kind_q <= new_kind;
      end
    end
  end

  always_comb begin
    unique case (kind_q)
      ilst_pkg::KindRange: rsp_status = ilst_pkg::StRange;
      ilst_pkg::KindFull:  rsp_status = ilst_pkg::StFull;
      default:             rsp_status = ilst_pkg::StDone;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      epos_q  <= new_epos[CW-1:0];
      value_q <= in_req_i.value;
    end
    if (cmd_i.rsp_load) begin
      rsp_q.read_value  <= (kind_q == ilst_pkg::KindRead) ? rdata_q : ilst_pkg::MissValue;
      rsp_q.status      <= rsp_status;
      rsp_q.list_length <= cnt_ext[6:0];
    end
  end

  assign out_rsp_o = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Capacity))
    else $error("element count exceeds capacity");

  a_write_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (waddr < CW'(Capacity)))
    else $error("memory write outside capacity");

  a_insert_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift_rd && kind_q == ilst_pkg::KindInsert) |-> (idx_q != '0))
    else $error("insert shift source underflow");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && kind_q == ilst_pkg::KindInsert) |=>
      (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the count");

endmodule

`default_nettype wire

/* src/ilst_ctrl.sv */
// ----------------------------------------------------------------------------
// ilst_ctrl
// Request sequencer: accepts a request, steps the datapath through the
// element shifts and the final step, and hands the response to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ilst_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire ilst_pkg::stat_t stat_i,
  output ilst_pkg::cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StDecide = 6'b000010,
    StShRd   = 6'b000100,
    StShWr   = 6'b001000,
    StFinal  = 6'b010000,
    StResp   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecide;
        end
      end
      StDecide: begin
        unique case (stat_i.kind)
          ilst_pkg::KindRead: begin
            cmd_o.decide_rd = 1'b1;
            state_d         = StFinal;
          end
          ilst_pkg::KindInsert, ilst_pkg::KindDelete: begin
            state_d = stat_i.more ? StShRd : StFinal;
          end
          default: begin
            state_d = StResp;
          end
        endcase
      end
      StShRd: begin
        cmd_o.shift_rd = 1'b1;
        state_d        = StShWr;
      end
      StShWr: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = StDecide;
      end
      StFinal: begin
        cmd_o.finish = 1'b1;
        state_d      = StResp;
      end
      StResp: begin
        if (out_free) begin
          cmd_o.rsp_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
